// ===== design/fpfl_pkg.sv =====
// Shared constants and types of the fixed-size pool free-list allocator.
`default_nettype none

package fpfl_pkg;

    // Pool geometry
    localparam int POOL_ITEMS = 1024;
    localparam int SLOT_AW    = $clog2(POOL_ITEMS);
    localparam int LINK_W     = $clog2(POOL_ITEMS + 1);

    // Field widths
    localparam int SIZE_W   = 16;
    localparam int SLOT_W   = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Empty marker for the free-list head
    localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(POOL_ITEMS);

    // Reset value of the item-size-limit configuration register
    localparam logic [SIZE_W-1:0] ITEM_SIZE_LIMIT_RST = SIZE_W'(64);

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE_LIMIT = CFG_IDX_W'(1);

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT     = 2'd0,
        ST_ALLOC_SYS = 2'd1,
        ST_RETURNED  = 2'd2,
        ST_FREE_SYS  = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== design/fpfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/fixed_pool_free_list_allocator_top.sv =====
// Top level of the fixed-size pool allocator with a LIFO free list.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  request  | start, busy (accept: start & !busy) | req_type, alloc_size, slot
//  result   | done (one-cycle strobe)    | status, granted_slot
//  config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One item per cycle; each accepted item passes through the input register
// and then the result register before its result is on the ports. The head's
// link is kept in a register; after a pop the new head's link comes back from
// the link RAM in the next cycle and is forwarded straight into the next item.
// rst_n clears control state at once; the link RAM is not cleared, a link
// is always written before it is read. busy stays low; results cannot be
// stalled, and config writes are always taken.
`default_nettype none

module fixed_pool_free_list_allocator_top
    import fpfl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  req_type,
    input  wire logic [SIZE_W-1:0]     alloc_size,
    input  wire logic [SLOT_W-1:0]     slot,
    // result
    output logic                       done,
    output logic      [STATUS_W-1:0]   status,
    output logic      [SLOT_W-1:0]     granted_slot,
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic              pool_enabled_reg;
    logic [SIZE_W-1:0] item_size_limit_reg;

    // Input register
    logic              in_valid_reg;
    logic              req_type_reg;
    logic [SIZE_W-1:0] alloc_size_reg;
    logic [SLOT_W-1:0] slot_reg;

    // Pool state
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] head_link_reg, head_link_next;
    logic [LINK_W-1:0] mark_reg, mark_next;
    logic              created_reg, created_next;
    logic              refill_reg, refill_next;

    // Result register
    logic              done_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;

    // Link RAM
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [SLOT_AW-1:0] ram_rd_addr;
    logic [LINK_W-1:0] ram_rd_data;

    logic [LINK_W-1:0] link_eff;
    logic              eligible;
    logic              slot_in_range;
    logic              do_pop;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_enabled_reg    <= 1'b1;
            item_size_limit_reg <= ITEM_SIZE_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POOL_ENABLED:    pool_enabled_reg    <= cfg_data[0];
                CFG_ITEM_SIZE_LIMIT: item_size_limit_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_type_reg   <= req_type;
            alloc_size_reg <= alloc_size;
            slot_reg       <= slot;
        end
    end

    // Head link: forward the RAM data in the cycle after a pop
    assign link_eff = refill_reg ? ram_rd_data : head_link_reg;

    assign eligible      = pool_enabled_reg && (alloc_size_reg <= item_size_limit_reg);
    assign slot_in_range = (slot_reg != '0) && (slot_reg < SLOT_W'(POOL_ITEMS));

    // Request processing
    always_comb
    begin
        head_next      = head_reg;
        head_link_next = link_eff;
        mark_next      = mark_reg;
        created_next   = created_reg;
        refill_next    = 1'b0;
        status_next    = ST_ALLOC_SYS;
        granted_next   = '0;
        ram_wr_en      = 1'b0;
        do_pop         = 1'b0;

        if (in_valid_reg)
        begin
            case (req_type_reg)
                REQ_ALLOC:
                begin
                    if (eligible)
                    begin
                        created_next = 1'b1;
                        if (head_reg < LINK_EMPTY)
                        begin
                            // pop the free-list head
                            do_pop       = 1'b1;
                            refill_next  = 1'b1;
                            head_next    = (link_eff > LINK_EMPTY) ? LINK_EMPTY : link_eff;
                            status_next  = ST_GRANT;
                            granted_next = SLOT_W'(head_reg);
                        end
                        else if (mark_reg < LINK_EMPTY)
                        begin
                            // hand out the next never-used slot
                            mark_next    = mark_reg + LINK_W'(1);
                            status_next  = ST_GRANT;
                            granted_next = SLOT_W'(mark_reg);
                        end
                    end
                end
                REQ_FREE:
                begin
                    if (created_reg && slot_in_range)
                    begin
                        // push: link gets the old head
                        ram_wr_en      = 1'b1;
                        head_link_next = head_reg;
                        head_next      = LINK_W'(slot_reg[SLOT_AW-1:0]);
                        status_next    = ST_RETURNED;
                    end
                    else
                    begin
                        status_next = ST_FREE_SYS;
                    end
                end
                default:
                begin
                    status_next = ST_FREE_SYS;
                end
            endcase
        end
    end

    assign ram_rd_en   = do_pop;
    assign ram_rd_addr = link_eff[SLOT_AW-1:0];

    // Pool state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= LINK_EMPTY;
            mark_reg    <= LINK_W'(1);
            created_reg <= 1'b0;
            refill_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            mark_reg    <= mark_next;
            created_reg <= created_next;
            refill_reg  <= refill_next;
            done_reg    <= in_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_link_reg <= head_link_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
    end

    fpfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_ITEMS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg[SLOT_AW-1:0]),
        .wr_data (head_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;

    // Checks
    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted item produced no result");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_GRANT) |->
            (granted_slot != '0) && (granted_slot < SLOT_W'(POOL_ITEMS)))
        else $error("granted slot out of range");

    a_mark_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        mark_reg <= LINK_EMPTY && mark_reg != '0)
        else $error("watermark out of range");

    a_refill_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        refill_reg |-> $past(do_pop))
        else $error("link refill without a pop");

endmodule

`default_nettype wire
